// File: hdl/deq_pkg.sv
package deq_pkg;

  localparam int unsigned Depth = 64;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned DataW = 32;
  localparam int unsigned FillW = 7;

  typedef enum logic [1:0] {
    OpPushBack  = 2'd0,
    OpPushFront = 2'd1,
    OpPopBack   = 2'd2,
    OpPopFront  = 2'd3
  } op_e;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  // base + off modulo Depth, with base < Depth and off <= Depth
  function automatic idx_t ring_pos(idx_t base, cnt_t off);
    logic [CntW:0] sum;
    sum = {{(CntW + 1 - IdxW){1'b0}}, base} + {1'b0, off};
    if (sum >= (CntW + 1)'(Depth)) begin
      sum = sum - (CntW + 1)'(Depth);
    end
    return sum[IdxW-1:0];
  endfunction

  function automatic idx_t ring_dec(idx_t base);
    if (base == '0) begin
      return IdxW'(Depth - 1);
    end
    return base - 1'b1;
  endfunction

  function automatic idx_t ring_inc(idx_t base);
    if (base == IdxW'(Depth - 1)) begin
      return '0;
    end
    return base + 1'b1;
  endfunction

endpackage

// File: hdl/double_ended_queue_top.sv
// Channel   Handshake            Payload
// command   start_i / busy_o     operation_i, data_in_i
// result    done_o (strobe)      data_out_o, pop_was_empty_o, push_dropped_o,
//                                now_empty_o, fill_count_o
//
// One beat per cycle: busy_o stays low and each result appears in the cycle after
// its command, as the read of the entry memory is registered.
// A push writes the memory at its accept edge; a pop reads it at its accept edge,
// so a later pop always sees an earlier push.
// Reset clears the front index and count at once; the memory is not cleared.
// The receiver cannot stall; done_o is high for exactly one cycle per result.
module double_ended_queue_top
  import deq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              operation_i,
  input  logic signed [DataW-1:0] data_in_i,
  output logic                    done_o,
  output logic signed [DataW-1:0] data_out_o,
  output logic                    pop_was_empty_o,
  output logic                    push_dropped_o,
  output logic                    now_empty_o,
  output logic [FillW-1:0]        fill_count_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_q;

  idx_t front_q, front_d;
  cnt_t count_q, count_d;
  logic done_q;
  logic pop_ok_q, pop_ok_d;
  logic empty_pop_q, empty_pop_d;
  logic dropped_q, dropped_d;

  logic accept;
  logic we, re;
  idx_t waddr, raddr;
  op_e  op;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign op     = op_e'(operation_i);

  always_comb begin
    front_d     = front_q;
    count_d     = count_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = front_q;
    raddr       = front_q;
    pop_ok_d    = 1'b0;
    empty_pop_d = 1'b0;
    dropped_d   = 1'b0;
    if (accept) begin
      unique case (op)
        OpPushBack: begin
          if (count_q >= CntW'(Depth)) begin
            dropped_d = 1'b1;
          end else begin
            we      = 1'b1;
            waddr   = ring_pos(front_q, count_q);
            count_d = count_q + 1'b1;
          end
        end
        OpPushFront: begin
          if (count_q >= CntW'(Depth)) begin
            dropped_d = 1'b1;
          end else begin
            we      = 1'b1;
            front_d = ring_dec(front_q);
            waddr   = front_d;
            count_d = count_q + 1'b1;
          end
        end
        OpPopBack: begin
          if (count_q == '0) begin
            empty_pop_d = 1'b1;
          end else begin
            re       = 1'b1;
            pop_ok_d = 1'b1;
            count_d  = count_q - 1'b1;
            raddr    = ring_pos(front_q, count_d);
          end
        end
        OpPopFront: begin
          if (count_q == '0) begin
            empty_pop_d = 1'b1;
          end else begin
            re       = 1'b1;
            pop_ok_d = 1'b1;
            raddr    = front_q;
            front_d  = ring_inc(front_q);
            count_d  = count_q - 1'b1;
          end
        end
        default: begin
          empty_pop_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= data_in_i;
    end
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      done_q      <= 1'b0;
      pop_ok_q    <= 1'b0;
      empty_pop_q <= 1'b0;
      dropped_q   <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      done_q      <= accept;
      pop_ok_q    <= pop_ok_d;
      empty_pop_q <= empty_pop_d;
      dropped_q   <= dropped_d;
    end
  end

  always_comb begin
    if (pop_ok_q) begin
      data_out_o = rd_q;
    end else if (empty_pop_q) begin
      data_out_o = '1;
    end else begin
      data_out_o = '0;
    end
  end

  assign done_o          = done_q;
  assign pop_was_empty_o = empty_pop_q;
  assign push_dropped_o  = dropped_q;
  assign now_empty_o     = (count_q == '0);
  assign fill_count_o    = FillW'(count_q);

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("entry count above depth");

  a_front_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= IdxW'(Depth - 1))
    else $error("front index out of range");

  a_done_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("missing result strobe");

  a_drop_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && push_dropped_o |-> count_q == CntW'(Depth))
    else $error("push dropped while not full");

  a_empty_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && pop_was_empty_o |-> now_empty_o && !push_dropped_o)
    else $error("empty pop with entries present");

endmodule
